// ===== hw/rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: shared package
// Holds the types, character codes and port constants that the front, the
// queue and the back of the writer use.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Field widths fixed by the interface.
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int DATA_W  = 16;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    // A cursor position is row * columns + column and is held in twelve bits.
    localparam int POS_W   = 12;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Character codes with a special meaning.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

    // Kinds of write on the result channel.
    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_PORT = 1'b1;

    // CRTC ports and cursor registers.
    localparam logic [ADDR_W-1:0] CRTC_INDEX_PORT  = 11'h3D4;
    localparam logic [ADDR_W-1:0] CRTC_DATA_PORT   = 11'h3D5;
    localparam logic [DATA_W-1:0] CRTC_CURSOR_LOW  = 16'h000F;
    localparam logic [DATA_W-1:0] CRTC_CURSOR_HIGH = 16'h000E;

    // Class of an incoming character.
    typedef enum logic [1:0] {
        CLS_PRINT,
        CLS_NEWLINE,
        CLS_BACKSPACE
    } char_class_t;

    // Step of the back end while it plays out one command.
    typedef enum logic [2:0] {
        STEP_CELL,
        STEP_IDX_LO,
        STEP_DAT_LO,
        STEP_IDX_HI,
        STEP_DAT_HI
    } step_t;

    // One queued command: an optional cell write and the new cursor position.
    typedef struct packed {
        logic                has_cell;
        logic [ADDR_W-1:0]   cell_addr;
        logic [DATA_W-1:0]   cell_data;
        logic [POS_W-1:0]    cursor_pos;
    } queue_cmd_t;

    // Sorts a character code into its class.
    function automatic char_class_t classify(input logic [CHAR_W-1:0] code);
        char_class_t cls;
        if (code == CHAR_NEWLINE)
        begin
            cls = CLS_NEWLINE;
        end
        else if (code == CHAR_BACKSPACE)
        begin
            cls = CLS_BACKSPACE;
        end
        else
        begin
            cls = CLS_PRINT;
        end
        return cls;
    endfunction

endpackage

// ===== hw/rtl/tccw_if.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: channel interfaces
// Valid/ready channels for incoming characters and for outgoing writes.
// ----------------------------------------------------------------------------
interface tccw_char_if;
    import tccw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tccw_write_if;
    import tccw_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_kind;
    logic [ADDR_W-1:0] target_address;
    logic [DATA_W-1:0] write_data;
    logic              last_write;

    modport source (output valid, output write_kind, output target_address,
                    output write_data, output last_write, input ready);
    modport sink   (input valid, input write_kind, input target_address,
                    input write_data, input last_write, output ready);
endinterface

// ===== hw/rtl/tccw_front.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: front end
// Accepts characters, keeps the cursor and turns each character into one
// queued command: an optional cell write plus the new cursor position.
// ----------------------------------------------------------------------------
module tccw_front #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int START_ROW = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tccw_pkg::ATTR_W-1:0] char_attribute,
    input  logic                        push_ok,
    output logic                        push,
    output tccw_pkg::queue_cmd_t        push_cmd,
    tccw_char_if.sink                   chars
);
    import tccw_pkg::*;

    localparam logic [POS_W-1:0] COLS_POS   = POS_W'(COLUMNS);
    localparam logic [COL_W:0]   COLS_WIDE  = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]   ROWS_WIDE  = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0] ROW_RESET  = ROW_W'(START_ROW);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    char_class_t      cls;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_down;
    logic [COL_W-1:0] cell_col;
    logic [CHAR_W-1:0] cell_char;
    logic             has_cell;
    logic [POS_W-1:0] cell_idx;
    logic [POS_W-1:0] new_pos;

    // The queue has room, so a character may enter.
    assign chars.ready = push_ok;
    assign push        = chars.valid && push_ok;

    // Classify the character and work out the cell write and the new cursor.
    always_comb
    begin
        cls      = classify(chars.char_code);
        // The column counts modulo its own width before the wrap test.
        col_inc  = col_reg + COL_W'(1);
        // No scrolling: the row stops at the last one.
        if (({1'b0, row_reg} + {{ROW_W{1'b0}}, 1'b1}) < ROWS_WIDE)
        begin
            row_down = row_reg + ROW_W'(1);
        end
        else
        begin
            row_down = row_reg;
        end

        col_next  = col_reg;
        row_next  = row_reg;
        cell_col  = col_reg;
        cell_char = chars.char_code;
        has_cell  = 1'b0;

        case (cls)
            CLS_NEWLINE:
            begin
                col_next = '0;
                row_next = row_down;
            end
            CLS_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_next  = col_reg - COL_W'(1);
                    cell_col  = col_reg - COL_W'(1);
                    cell_char = CHAR_SPACE;
                    has_cell  = 1'b1;
                end
            end
            CLS_PRINT:
            begin
                has_cell = 1'b1;
                if ({1'b0, col_inc} >= COLS_WIDE)
                begin
                    col_next = '0;
                    row_next = row_down;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
            default:
            begin
                has_cell = 1'b0;
            end
        endcase

        cell_idx = POS_W'(row_reg) * COLS_POS + POS_W'(cell_col);
        new_pos  = POS_W'(row_next) * COLS_POS + POS_W'(col_next);

        push_cmd.has_cell   = has_cell;
        push_cmd.cell_addr  = cell_idx[ADDR_W-1:0];
        push_cmd.cell_data  = {char_attribute, cell_char};
        push_cmd.cursor_pos = new_pos;
    end

    // Cursor registers, updated on every accepted character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= ROW_RESET;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== hw/rtl/tccw_queue.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: command queue
// A short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module tccw_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tccw_pkg::queue_cmd_t push_cmd,
    output logic                 push_ok,
    input  logic                 pop,
    output logic                 head_valid,
    output tccw_pkg::queue_cmd_t head_cmd
);
    import tccw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    queue_cmd_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ok    = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/tccw_back.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: back end
// Plays out the command at the head of the queue as an optional cell write and
// four CRTC port writes, one per cycle while the write channel is ready,
// through a registered output stage.
module tccw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  tccw_pkg::queue_cmd_t head_cmd,
    output logic                 pop,
    tccw_write_if.source         writes
);
    import tccw_pkg::*;

    step_t             step_reg, step_next, cur_step;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic              advance;

    assign writes.valid          = out_valid_reg;
    assign writes.write_kind     = kind_reg;
    assign writes.target_address = addr_reg;
    assign writes.write_data     = data_reg;
    assign writes.last_write     = last_reg;

    // Choose the next write and advance the step when the output stage frees.
    always_comb
    begin
        advance = head_valid && (!out_valid_reg || writes.ready);

        // A command without a cell write starts at the port writes.
        if (step_reg == STEP_CELL && !head_cmd.has_cell)
        begin
            cur_step = STEP_IDX_LO;
        end
        else
        begin
            cur_step = step_reg;
        end

        kind_next = KIND_PORT;
        addr_next = CRTC_INDEX_PORT;
        data_next = CRTC_CURSOR_LOW;
        last_next = 1'b0;
        step_next = step_reg;
        pop       = 1'b0;

        case (cur_step)
            STEP_CELL:
            begin
                kind_next = KIND_CELL;
                addr_next = head_cmd.cell_addr;
                data_next = head_cmd.cell_data;
                step_next = STEP_IDX_LO;
            end
            STEP_IDX_LO:
            begin
                step_next = STEP_DAT_LO;
            end
            STEP_DAT_LO:
            begin
                addr_next = CRTC_DATA_PORT;
                data_next = {8'h00, head_cmd.cursor_pos[7:0]};
                step_next = STEP_IDX_HI;
            end
            STEP_IDX_HI:
            begin
                data_next = CRTC_CURSOR_HIGH;
                step_next = STEP_DAT_HI;
            end
            STEP_DAT_HI:
            begin
                addr_next = CRTC_DATA_PORT;
                data_next = DATA_W'(head_cmd.cursor_pos[POS_W-1:8]);
                last_next = 1'b1;
                step_next = STEP_CELL;
                pop       = advance;
            end
            default:
            begin
                step_next = STEP_CELL;
            end
        endcase

        if (!advance)
        begin
            step_next = step_reg;
        end
        out_valid_next = advance || (out_valid_reg && !writes.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_CELL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded whenever a new write enters the stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= kind_next;
            addr_reg <= addr_next;
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== hw/rtl/text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text console character writer: top level
// Keeps a text cursor, writes character cells and updates the CRTC cursor.
// ----------------------------------------------------------------------------
// A character that is taken is stored in the queue; its first write then
// enters the registered output stage of the back end. A printable
// character or a backspace that writes a cell gives five writes, any other
// character four, on the single write channel that carries one write per
// cycle while it is ready. Reset is asynchronous and active low: the cursor
// goes to column 0 of START_ROW, the attribute to 2, queue and output stage empty.
module text_console_char_writer_top #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int START_ROW = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [tccw_pkg::ATTR_W-1:0] cfg_write_data,
    tccw_char_if.sink                   chars,
    tccw_write_if.source                writes
);
    import tccw_pkg::*;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd2;

    logic [ATTR_W-1:0] attr_reg;
    logic              push, push_ok, pop, head_valid;
    queue_cmd_t        push_cmd, head_cmd;

    // Attribute register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_write_en)
        begin
            attr_reg <= cfg_write_data;
        end
    end

    tccw_front #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .START_ROW (START_ROW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_attribute (attr_reg),
        .push_ok        (push_ok),
        .push           (push),
        .push_cmd       (push_cmd),
        .chars          (chars)
    );

    tccw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ok    (push_ok),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tccw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .writes     (writes)
    );

endmodule
